>>> hw/rtl/sxfd_pkg.sv
// Shared types, constants and arithmetic helpers of the stereo cross-feedback delay.
`default_nettype none

package sxfd_pkg;

   localparam int SampleBits   = 24;
   localparam int GainBits     = 16;
   localparam int DelayBits    = 17;
   localparam int DelayDepth   = 1 << DelayBits;
   localparam int FracBits     = 15;
   localparam int WideBits     = SampleBits + 2;
   localparam int ProdBits     = SampleBits + GainBits + 1;
   localparam int CsrIndexBits = 2;
   localparam int CsrDataBits  = DelayBits;
   localparam int RspDepth     = 4;
   localparam int RspPtrBits   = $clog2(RspDepth);
   localparam int CountBits    = $clog2(RspDepth + 1);

   localparam logic [GainBits-1:0]  GainUnity    = GainBits'(1 << FracBits);
   localparam logic [DelayBits-1:0] DelayReset   = DelayBits'(48000);
   localparam logic [GainBits-1:0]  GainReset    = GainBits'(16384);
   localparam logic [DelayBits-1:0] AddrMax      = {DelayBits{1'b1}};

   typedef enum logic [CsrIndexBits-1:0] {
      CsrDelay    = 2'd0,
      CsrFeedback = 2'd1,
      CsrWet      = 2'd2,
      CsrCross    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                         out_chan;
      logic signed [SampleBits-1:0] out_sample;
   } rsp_item_type;

   function automatic logic [GainBits-1:0] clamp_gain(input logic [GainBits-1:0] g);
      return (g > GainUnity) ? GainUnity : g;
   endfunction

   function automatic logic signed [SampleBits-1:0] sat_sample(
      input logic signed [WideBits-1:0] v
   );
      logic signed [SampleBits-1:0] res;
      if (!v[WideBits-1] && (|v[WideBits-2:SampleBits-1])) begin
         res = {1'b0, {(SampleBits-1){1'b1}}};
      end else if (v[WideBits-1] && !(&v[WideBits-2:SampleBits-1])) begin
         res = {1'b1, {(SampleBits-1){1'b0}}};
      end else begin
         res = v[SampleBits-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sxfd_if.sv
// Request and response channel interfaces of the stereo cross-feedback delay.
`default_nettype none

interface sxfd_req_if import sxfd_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         chan;
   logic signed [SampleBits-1:0] in_sample;

   modport source (output valid, output chan, output in_sample, input ready);
   modport sink   (input valid, input chan, input in_sample, output ready);
endinterface

interface sxfd_rsp_if import sxfd_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         out_chan;
   logic signed [SampleBits-1:0] out_sample;

   modport source (output valid, output out_chan, output out_sample, input ready);
   modport sink   (input valid, input out_chan, input out_sample, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sxfd_rsp_fifo.sv
// Small response queue that decouples the processing pipeline from the response channel.
`default_nettype none

module sxfd_rsp_fifo import sxfd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rsp_item_type         push_item,
   input  logic                 pop,
   output rsp_item_type         head_item,
   output logic                 not_empty,
   output logic [CountBits-1:0] count
);

   rsp_item_type            slot_ff [RspDepth];
   logic [RspPtrBits-1:0]   wr_ptr_ff;
   logic [RspPtrBits-1:0]   rd_ptr_ff;
   logic [CountBits-1:0]    count_ff;
   logic [CountBits-1:0]    count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

`default_nettype wire

>>> hw/rtl/stereo_cross_feedback_delay.sv
// Stereo feedback delay line with optional cross reading between the two channel stores.
//
// Requests arrive on req, one sample tagged with its channel; each request yields exactly
// one response on rsp, in request order, carrying the channel and the wet/dry mix.
// Registers are written on the csr port: delay, feedback gain, wet gain, cross mode.
// Each channel store is a synchronous memory with a registered read. A request is read in
// its accept cycle (stage 0), multiplied in stage 1, and saturated and written back in
// stage 2, which also queues its response. Throughput is one request per cycle while the
// queue has room. A request that reads the very entry the request just ahead of it writes
// waits until that request leaves stage 1; the value then comes from a bypass register.
// Reset clears the pipeline, the response queue, the write positions and the registers
// (delay 48000, gains one half, cross mode off). No clearing pass runs: entries never
// written since reset read as zero by comparison with the write position and wrap flag.
// When the receiver stalls, up to four responses are held in a queue; req.ready drops
// once queued plus in-flight requests reach that depth.
`default_nettype none

module stereo_cross_feedback_delay import sxfd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   sxfd_req_if.sink                req,
   sxfd_rsp_if.source              rsp,
   input  logic                    csr_we,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_wdata
);

   // Configuration registers.
   logic [DelayBits-1:0] delay_ff;
   logic [GainBits-1:0]  fbg_ff;
   logic [GainBits-1:0]  wet_ff;
   logic [GainBits-1:0]  dry_ff;
   logic                 cross_ff;
   logic [GainBits-1:0]  csr_gain;

   assign csr_gain = clamp_gain(csr_wdata[GainBits-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DelayReset;
         fbg_ff   <= GainReset;
         wet_ff   <= GainReset;
         dry_ff   <= GainUnity - GainReset;
         cross_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrDelay:    delay_ff <= csr_wdata[DelayBits-1:0];
            CsrFeedback: fbg_ff   <= csr_gain;
            CsrWet: begin
               wet_ff <= csr_gain;
               dry_ff <= GainUnity - csr_gain;
            end
            CsrCross:    cross_ff <= csr_wdata[0];
         endcase
      end
   end

   // Write positions and wrap flags of the two stores.
   logic [DelayBits-1:0] wp_l_ff, wp_l_in, wp_r_ff, wp_r_in;
   logic                 wrap_l_ff, wrap_l_in, wrap_r_ff, wrap_r_in;

   // Stage 0: address generation and memory read.
   logic                 s0_chan;
   logic                 s0_src;
   logic [DelayBits-1:0] s0_pos;
   logic [DelayBits-1:0] s0_rd;
   logic [DelayBits-1:0] s0_src_wp;
   logic                 s0_src_wrap;
   logic                 s0_filled;
   logic                 s0_zero;
   logic                 s0_hazard;
   logic                 s0_credit;
   logic                 s0_accept;
   logic [CountBits:0]   occupancy;
   logic [CountBits-1:0] fifo_count;

   // Stage 1 registers.
   logic                         s1_valid_ff;
   logic                         s1_chan_ff;
   logic                         s1_src_ff;
   logic signed [SampleBits-1:0] s1_x_ff;
   logic [DelayBits-1:0]         s1_pos_ff;
   logic [DelayBits-1:0]         s1_rd_ff;
   logic                         s1_filled_ff;
   logic                         s1_zero_ff;
   logic [SampleBits-1:0]        rdata_l_ff;
   logic [SampleBits-1:0]        rdata_r_ff;
   logic signed [SampleBits-1:0] s1_yn;
   logic signed [ProdBits-1:0]   p_fb_in, p_wet_in, p_dry_in;

   // Stage 2 registers.
   logic                         s2_valid_ff;
   logic                         s2_chan_ff;
   logic signed [SampleBits-1:0] s2_x_ff;
   logic [DelayBits-1:0]         s2_pos_ff;
   logic signed [ProdBits-1:0]   p_fb_ff, p_wet_ff, p_dry_ff;
   logic signed [ProdBits-1:0]   fb_round;
   logic signed [ProdBits-1:0]   mix_round;
   logic signed [WideBits-1:0]   store_sum;
   logic signed [SampleBits-1:0] store_val;
   logic signed [SampleBits-1:0] mix_val;

   // Bypass register holding the most recent store write.
   logic                         lw_valid_ff;
   logic                         lw_chan_ff;
   logic [DelayBits-1:0]         lw_addr_ff;
   logic signed [SampleBits-1:0] lw_data_ff;

   logic [SampleBits-1:0] left_mem  [DelayDepth];
   logic [SampleBits-1:0] right_mem [DelayDepth];

   localparam logic signed [ProdBits-1:0] RoundHalf = ProdBits'(1 << (FracBits - 1));

   assign s0_chan     = req.chan;
   assign s0_src      = cross_ff ? !s0_chan : s0_chan;
   assign s0_pos      = s0_chan ? wp_r_ff : wp_l_ff;
   assign s0_rd       = s0_pos - delay_ff;
   assign s0_src_wp   = s0_src ? wp_r_ff : wp_l_ff;
   assign s0_src_wrap = s0_src ? wrap_r_ff : wrap_l_ff;
   assign s0_filled   = s0_src_wrap || (s0_rd < s0_src_wp);
   assign s0_zero     = (delay_ff == '0);
   assign s0_hazard   = s1_valid_ff && !s0_zero && (s1_chan_ff == s0_src)
                        && (s1_pos_ff == s0_rd);
   assign occupancy   = {1'b0, fifo_count} + (CountBits+1)'(s1_valid_ff)
                        + (CountBits+1)'(s2_valid_ff);
   assign s0_credit   = occupancy < (CountBits+1)'(RspDepth);
   assign req.ready   = s0_credit && !s0_hazard;
   assign s0_accept   = req.valid && req.ready;

   always_comb begin
      wp_l_in   = wp_l_ff;
      wp_r_in   = wp_r_ff;
      wrap_l_in = wrap_l_ff;
      wrap_r_in = wrap_r_ff;
      if (s0_accept && !s0_chan) begin
         wp_l_in = wp_l_ff + 1'b1;
         if (wp_l_ff == AddrMax) begin
            wrap_l_in = 1'b1;
         end
      end
      if (s0_accept && s0_chan) begin
         wp_r_in = wp_r_ff + 1'b1;
         if (wp_r_ff == AddrMax) begin
            wrap_r_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_l_ff     <= '0;
         wp_r_ff     <= '0;
         wrap_l_ff   <= 1'b0;
         wrap_r_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         lw_valid_ff <= 1'b0;
      end else begin
         wp_l_ff     <= wp_l_in;
         wp_r_ff     <= wp_r_in;
         wrap_l_ff   <= wrap_l_in;
         wrap_r_ff   <= wrap_r_in;
         s1_valid_ff <= s0_accept;
         s2_valid_ff <= s1_valid_ff;
         if (s2_valid_ff) begin
            lw_valid_ff <= 1'b1;
         end
      end
   end

   // Memories: write from stage 2, read at the stage 0 address.
   always_ff @(posedge clock) begin
      if (s2_valid_ff && !s2_chan_ff) begin
         left_mem[s2_pos_ff] <= store_val;
      end
      rdata_l_ff <= left_mem[s0_rd];
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s2_chan_ff) begin
         right_mem[s2_pos_ff] <= store_val;
      end
      rdata_r_ff <= right_mem[s0_rd];
   end

   always_ff @(posedge clock) begin
      s1_chan_ff   <= s0_chan;
      s1_src_ff    <= s0_src;
      s1_x_ff      <= req.in_sample;
      s1_pos_ff    <= s0_pos;
      s1_rd_ff     <= s0_rd;
      s1_filled_ff <= s0_filled;
      s1_zero_ff   <= s0_zero;
   end

   // Stage 1: select the delayed sample and form the products.
   always_comb begin
      priority if (s1_zero_ff) begin
         s1_yn = s1_x_ff;
      end else if (!s1_filled_ff) begin
         s1_yn = '0;
      end else if (lw_valid_ff && (lw_chan_ff == s1_src_ff) && (lw_addr_ff == s1_rd_ff)) begin
         s1_yn = lw_data_ff;
      end else begin
         s1_yn = s1_src_ff ? rdata_r_ff : rdata_l_ff;
      end
   end

   assign p_fb_in  = $signed({1'b0, fbg_ff}) * s1_yn;
   assign p_wet_in = $signed({1'b0, wet_ff}) * s1_yn;
   assign p_dry_in = $signed({1'b0, dry_ff}) * s1_x_ff;

   always_ff @(posedge clock) begin
      s2_chan_ff <= s1_chan_ff;
      s2_x_ff    <= s1_x_ff;
      s2_pos_ff  <= s1_pos_ff;
      p_fb_ff    <= p_fb_in;
      p_wet_ff   <= p_wet_in;
      p_dry_ff   <= p_dry_in;
   end

   // Stage 2: round, add, saturate; write back and queue the response.
   assign fb_round  = (p_fb_ff + RoundHalf) >>> FracBits;
   assign store_sum = WideBits'(s2_x_ff) + fb_round[WideBits-1:0];
   assign store_val = sat_sample(store_sum);
   assign mix_round = (p_wet_ff + p_dry_ff + RoundHalf) >>> FracBits;
   assign mix_val   = sat_sample(mix_round[WideBits-1:0]);

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         lw_chan_ff <= s2_chan_ff;
         lw_addr_ff <= s2_pos_ff;
         lw_data_ff <= store_val;
      end
   end

   rsp_item_type push_item;
   rsp_item_type head_item;
   logic         fifo_not_empty;

   assign push_item.out_chan   = s2_chan_ff;
   assign push_item.out_sample = mix_val;

   sxfd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_item (push_item),
      .pop       (rsp.valid && rsp.ready),
      .head_item (head_item),
      .not_empty (fifo_not_empty),
      .count     (fifo_count)
   );

   assign rsp.valid      = fifo_not_empty;
   assign rsp.out_chan   = head_item.out_chan;
   assign rsp.out_sample = head_item.out_sample;

endmodule

`default_nettype wire

>>> hw/rtl/sxfd_checker.sv
// Port-level checker of the stereo cross-feedback delay and its bind to the top level.
`default_nettype none

module sxfd_checker import sxfd_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_out_chan,
   input logic signed [SampleBits-1:0] rsp_out_sample
);

   logic [CountBits:0] outstanding_ff;
   logic [CountBits:0] outstanding_in;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_valid && req_ready && !(rsp_valid && rsp_ready)) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (!(req_valid && req_ready) && rsp_valid && rsp_ready) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outstanding_ff != '0))
      else $error("response without an outstanding request");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= (CountBits+1)'(RspDepth))
      else $error("more requests in flight than the response queue holds");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_chan)
      && $stable(rsp_out_sample))
      else $error("stalled response changed");

endmodule

bind stereo_cross_feedback_delay sxfd_checker u_sxfd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_out_chan   (rsp.out_chan),
   .rsp_out_sample (rsp.out_sample)
);

`default_nettype wire
